/* rtl/sorted_key_record_table_macros.svh */
// assertion macros for the sorted key record table
// no dependencies; included by the modules that carry assertions
`ifndef SORTED_KEY_RECORD_TABLE_MACROS_SVH
`define SORTED_KEY_RECORD_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define SKRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skrt assertion failed");
`define SKRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skrt assertion failed");
`else
`define SKRT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SKRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/skrt_pkg.sv */
// shared types and constants for the sorted key record table
// no dependencies; used by skrt_cell and sorted_key_record_table
package skrt_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int KEY_W    = 32;
    localparam int PAGE_W   = 31;
    localparam int SLOT_W   = 16;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOCATE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOKEY = 2'd2;
    localparam logic [1:0] ST_NOREC = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_OUT  = 3'b100
    } skrt_state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAGE_W-1:0]       page;
        logic [SLOT_W-1:0]       slot;
    } skrt_entry_t;

    typedef struct packed {
        logic        ins;
        skrt_entry_t data;
    } skrt_op_t;

    typedef struct packed {
        logic occ;
        logic at_end;
        logic rd_sel;
    } skrt_cell_ctl_t;

endpackage

/* rtl/skrt_cell.sv */
// one slot of the sorted row: holds a pair, compares it, shifts from its neighbor
// depends on skrt_pkg
module skrt_cell (
    input  logic                    clk,
    input  skrt_pkg::skrt_op_t      op,
    input  skrt_pkg::skrt_cell_ctl_t ctl,
    input  skrt_pkg::skrt_entry_t   prev_entry,
    input  logic                    prev_take,
    output logic                    take,
    output skrt_pkg::skrt_entry_t   entry,
    output skrt_pkg::skrt_entry_t   rd_entry
);

    skrt_pkg::skrt_entry_t entry_reg;
    skrt_pkg::skrt_entry_t entry_next;

    assign take     = ctl.occ && ($signed(op.data.key) <= $signed(entry_reg.key));
    assign entry    = entry_reg;
    assign rd_entry = ctl.rd_sel ? entry_reg : '0;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.ins)
        begin
            if (prev_take)
            begin
                entry_next = prev_entry;
            end
            else if (take || ctl.at_end)
            begin
                entry_next = op.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/sorted_key_record_table.sv */
// Sorted key/record table, a B+tree leaf of up to skrt_pkg::CAPACITY pairs kept in
// ascending key order in a row of compare-and-shift cells. A beat is captured at its
// accepting edge; in the next cycle every cell compares against the key in parallel (and
// shifts on insert); in the cycle after that the locate position is encoded and the result
// register loads unless the result stalls. The input stalls until the result register
// loads, so a new beat is not taken while one is in flight; a stalled result holds that
// load until the result register frees.
// depends on skrt_pkg, skrt_cell and sorted_key_record_table_macros.svh
`include "sorted_key_record_table_macros.svh"

module sorted_key_record_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [1:0]                   kind,
    input  logic signed [31:0]           key,
    input  logic [30:0]                  record_page,
    input  logic [15:0]                  record_slot,
    input  logic [6:0]                   entry_number,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [1:0]                   status,
    output logic [6:0]                   found_position,
    output logic signed [31:0]           entry_key,
    output logic [30:0]                  entry_page,
    output logic [15:0]                  entry_slot,
    output logic [6:0]                   stored_count
);

    localparam int CAP = skrt_pkg::CAPACITY;
    localparam int CW  = skrt_pkg::CNT_W;
    localparam int PW  = skrt_pkg::POS_W;

    skrt_pkg::skrt_state_t state_reg, state_next;
    logic [CW-1:0]         count_reg;
    logic [1:0]            kind_reg;
    skrt_pkg::skrt_entry_t req_data_reg;
    logic [PW-1:0]         pos_reg;

    logic [CAP-1:0]        edge_vec_reg;
    logic [1:0]            pend_status_reg;
    skrt_pkg::skrt_entry_t rd_data_reg;

    logic                  rsp_valid_reg;
    logic [1:0]            status_reg;
    logic [PW-1:0]         found_reg;
    skrt_pkg::skrt_entry_t rsp_data_reg;
    logic [PW-1:0]         stored_count_reg;

    skrt_pkg::skrt_op_t    op;
    logic                  full;
    logic                  req_take;
    logic                  rsp_load;
    logic                  rd_bad;
    logic [CAP-1:0]        take_vec;
    logic [CAP-1:0]        edge_vec;
    skrt_pkg::skrt_entry_t cell_entry [CAP];
    skrt_pkg::skrt_entry_t cell_rd [CAP];
    skrt_pkg::skrt_entry_t rd_or;
    logic [PW-1:0]         found_enc;

    assign full     = (count_reg == CW'(CAP));
    assign req_stall = (state_reg != skrt_pkg::S_IDLE);
    assign req_take = req_valid && !req_stall;
    assign rsp_load = (state_reg == skrt_pkg::S_OUT) && (!rsp_valid_reg || !rsp_stall);
    assign rd_bad   = (pos_reg == '0) || (pos_reg > PW'(count_reg));

    assign op.ins  = (state_reg == skrt_pkg::S_CMP) && (kind_reg == skrt_pkg::KIND_INSERT)
                     && !full;
    assign op.data = req_data_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++)
        begin : g_cell
            skrt_pkg::skrt_cell_ctl_t ctl;
            skrt_pkg::skrt_entry_t    prev_entry;
            logic                     prev_take;

            assign ctl.occ    = (CW'(gi) < count_reg);
            assign ctl.at_end = (CW'(gi) == count_reg);
            assign ctl.rd_sel = ctl.occ && (pos_reg == PW'(gi + 1));

            if (gi == 0)
            begin : g_head
                assign prev_entry = '0;
                assign prev_take  = 1'b0;
            end
            else
            begin : g_body
                assign prev_entry = cell_entry[gi-1];
                assign prev_take  = take_vec[gi-1];
            end

            assign edge_vec[gi] = take_vec[gi] && !prev_take;

            skrt_cell u_cell (
                .clk        (clk),
                .op         (op),
                .ctl        (ctl),
                .prev_entry (prev_entry),
                .prev_take  (prev_take),
                .take       (take_vec[gi]),
                .entry      (cell_entry[gi]),
                .rd_entry   (cell_rd[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAP; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    // the edge vector has at most one bit set, so an or of the positions encodes it
    always_comb
    begin
        found_enc = '0;
        for (int i = 0; i < CAP; i++)
        begin
            if (edge_vec_reg[i])
            begin
                found_enc = found_enc | PW'(i + 1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skrt_pkg::S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = skrt_pkg::S_CMP;
                end
            end
            skrt_pkg::S_CMP:
            begin
                state_next = skrt_pkg::S_OUT;
            end
            skrt_pkg::S_OUT:
            begin
                if (rsp_load)
                begin
                    state_next = skrt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skrt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skrt_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (op.ins)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            kind_reg          <= kind;
            req_data_reg.key  <= key;
            req_data_reg.page <= record_page;
            req_data_reg.slot <= record_slot;
            pos_reg           <= entry_number;
        end

        if (state_reg == skrt_pkg::S_CMP)
        begin
            edge_vec_reg <= edge_vec;
            rd_data_reg  <= (kind_reg == skrt_pkg::KIND_READ) ? rd_or : '0;
            case (kind_reg)
                skrt_pkg::KIND_INSERT:
                begin
                    pend_status_reg <= full ? skrt_pkg::ST_FULL : skrt_pkg::ST_OK;
                end
                skrt_pkg::KIND_READ:
                begin
                    pend_status_reg <= rd_bad ? skrt_pkg::ST_NOREC : skrt_pkg::ST_OK;
                end
                default:
                begin
                    pend_status_reg <= skrt_pkg::ST_OK;
                end
            endcase
        end

        if (rsp_load)
        begin
            rsp_data_reg     <= rd_data_reg;
            stored_count_reg <= PW'(count_reg);
            if (kind_reg == skrt_pkg::KIND_LOCATE)
            begin
                status_reg <= (|edge_vec_reg) ? skrt_pkg::ST_OK : skrt_pkg::ST_NOKEY;
                found_reg  <= found_enc;
            end
            else
            begin
                status_reg <= pend_status_reg;
                found_reg  <= '0;
            end
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign entry_key      = rsp_data_reg.key;
    assign entry_page     = rsp_data_reg.page;
    assign entry_slot     = rsp_data_reg.slot;
    assign stored_count   = stored_count_reg;

    `SKRT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAP))
    `SKRT_ASSERT_NEXT(a_insert_grows, clk, rst_n, op.ins,
        count_reg == $past(count_reg) + CW'(1))
    `SKRT_ASSERT_NEXT(a_full_holds, clk, rst_n,
        (state_reg == skrt_pkg::S_CMP) && full, count_reg == $past(count_reg))
    `SKRT_ASSERT_NOW(a_edge_onehot, clk, rst_n, state_reg == skrt_pkg::S_OUT,
        $onehot0(edge_vec_reg))

endmodule
